/* rtl/core/pngenc_pkg.sv */
// ----------------------------------------------------------------------------
// pngenc_pkg: shared types and constants of the stored-block PNG encoder
// Payload structs, controller/datapath command and status, CRC byte update.
// ----------------------------------------------------------------------------
package pngenc_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       file_end;
    } t_out_item;

    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // register indexes of the configuration channel
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [14:0] DIM_MAX = 15'd16384;
    localparam logic [15:0] ADLER_MOD = 16'd65521;
    localparam logic [31:0] CRC_POLY = 32'hedb88320;

    // byte source selectors
    typedef enum logic [3:0] {
        SRC_HDR    = 4'd0,  // start header sequence ROM / computed fields
        SRC_BLKHDR = 4'd1,  // stored block header byte
        SRC_DATA   = 4'd2,  // filtered data byte
        SRC_TRAIL  = 4'd3   // trailer sequence
    } t_src;

    typedef struct packed {
        logic       start_frame;  // latch dims, clear state
        logic       load_pixel;   // capture rgb
        logic       emit;         // send one byte
        t_src       src;
        logic [5:0] idx;          // byte index within sequence
        logic [1:0] dsel;         // data byte: 0 filter, 1 r, 2 g, 3 b
        logic       crc_en;
        logic       crc_close;    // reset crc after byte
        logic       last;         // run_last
        logic       fend;         // file_end
        logic       end_frame;
        logic       pix_done;     // advance column
    } t_cmd;

    typedef struct packed {
        logic       col_zero;
        logic       blk_zero;     // block_bytes_left == 0
        logic       stream_zero;  // stream_bytes_left == 0
        logic       active;
    } t_status;

    function automatic logic [31:0] crc_upd(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

endpackage

/* rtl/core/pngenc_ctrl.sv */
// ----------------------------------------------------------------------------
// pngenc_ctrl: sequencing controller
// Walks the header, block header, data and trailer byte sequences.
// ----------------------------------------------------------------------------
module pngenc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_op,
    output logic                  o_stall,
    input  logic                  i_out_free,
    input  pngenc_pkg::t_status   i_sts,
    output pngenc_pkg::t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HDR    = 6'b000010,
        S_BLKHDR = 6'b000100,
        S_DATA   = 6'b001000,
        S_CHECK  = 6'b010000,
        S_TRAIL  = 6'b100000
    } t_state;

    localparam logic [5:0] HDR_LAST   = 6'd42;
    localparam logic [5:0] TRAIL_LAST = 6'd19;

    t_state     r_state, n_state;
    logic [5:0] r_idx, n_idx;
    logic [1:0] r_dsel, n_dsel;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_dsel  = r_dsel;
        o_cmd   = '0;
        o_cmd.src  = pngenc_pkg::SRC_HDR;
        o_cmd.idx  = r_idx;
        o_cmd.dsel = r_dsel;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == pngenc_pkg::OP_START) begin
                        o_cmd.start_frame = 1'b1;
                        n_state = S_HDR;
                        n_idx   = '0;
                    end else if (i_sts.active) begin
                        o_cmd.load_pixel = 1'b1;
                        n_dsel  = i_sts.col_zero ? 2'd0 : 2'd1;
                        n_state = S_DATA;
                    end
                end
            end
            S_HDR: begin
                o_cmd.src    = pngenc_pkg::SRC_HDR;
                o_cmd.crc_en = !((r_idx < 6'd12) || (r_idx >= 6'd29 && r_idx <= 6'd36));
                o_cmd.crc_close = (r_idx == 6'd32);
                o_cmd.last   = (r_idx == HDR_LAST);
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_idx = r_idx + 6'd1;
                    if (r_idx == HDR_LAST) n_state = S_IDLE;
                end
            end
            S_DATA: begin
                if (i_sts.blk_zero) begin
                    n_state = S_BLKHDR;
                    n_idx   = '0;
                end else begin
                    o_cmd.src    = pngenc_pkg::SRC_DATA;
                    o_cmd.crc_en = 1'b1;
                    if (i_out_free) begin
                        o_cmd.emit = 1'b1;
                        n_dsel = r_dsel + 2'd1;
                        if (r_dsel == 2'd3) begin
                            o_cmd.pix_done = 1'b1;
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_BLKHDR: begin
                o_cmd.src    = pngenc_pkg::SRC_BLKHDR;
                o_cmd.crc_en = 1'b1;
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_idx = r_idx + 6'd1;
                    if (r_idx == 6'd4) n_state = S_DATA;
                end
            end
            S_CHECK: begin
                // last byte already sent without run_last; mark decided here
                if (i_sts.stream_zero) begin
                    n_state = S_TRAIL;
                    n_idx   = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TRAIL: begin
                o_cmd.src    = pngenc_pkg::SRC_TRAIL;
                o_cmd.crc_en = (r_idx < 6'd4) || (r_idx >= 6'd12 && r_idx < 6'd16);
                o_cmd.crc_close = (r_idx == 6'd7);
                o_cmd.last   = (r_idx == TRAIL_LAST);
                o_cmd.fend   = (r_idx == TRAIL_LAST);
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_idx = r_idx + 6'd1;
                    if (r_idx == TRAIL_LAST) begin
                        o_cmd.end_frame = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_dsel  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_dsel  <= n_dsel;
        end
    end

endmodule

/* rtl/core/pngenc_dp.sv */
// ----------------------------------------------------------------------------
// pngenc_dp: datapath
// Frame counters, CRC-32, Adler-32, byte mux and output register.
// ----------------------------------------------------------------------------
module pngenc_dp #(
    parameter int BLOCK_MAX_BYTES = 65535
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [14:0]           i_width,
    input  logic [14:0]           i_height,
    input  pngenc_pkg::t_in_item  i_item,
    input  pngenc_pkg::t_cmd      i_cmd,
    output pngenc_pkg::t_status   o_sts,
    output logic                  o_out_free,
    output logic                  o_valid,
    input  logic                  i_stall,
    output pngenc_pkg::t_out_item o_item
);

    localparam int EFF_BLOCK = (BLOCK_MAX_BYTES < 2) ? 2 : BLOCK_MAX_BYTES;
    localparam logic [15:0] EFF16 = 16'(EFF_BLOCK);
    // ceil(2^47 / block size): exact quotient for any dividend below 2^31
    localparam logic [46:0] NB_RECIP =
        47'(((64'd1 << 47) + 64'(EFF_BLOCK) - 64'd1) / 64'(EFF_BLOCK));

    logic [14:0] r_fw, r_fh;
    logic [31:0] r_crc;
    logic [15:0] r_sa, r_sb;
    logic [13:0] r_col;
    logic [15:0] r_blk;
    logic [29:0] r_stream;
    logic        r_active;
    logic [7:0]  r_r, r_g, r_b;
    logic [31:0] r_idat_len;  // registered from r_d through r_x, r_p_lo/r_p_hi and r_nb after start
    logic [29:0] r_d;
    logic [30:0] r_x;
    logic [54:0] r_p_lo;
    logic [53:0] r_p_hi;
    logic [30:0] r_nb;
    pngenc_pkg::t_out_item r_out;
    logic        r_oval;
    logic        r_last_pend;

    logic [14:0] w_fw, w_fh;
    logic [15:0] w_len;
    logic [7:0]  w_byte;
    logic [16:0] w_sa, w_sb;
    logic [77:0] w_q;

    assign w_fw = (i_width == 15'd0) ? 15'd1 :
                  (i_width > pngenc_pkg::DIM_MAX) ? pngenc_pkg::DIM_MAX : i_width;
    assign w_fh = (i_height == 15'd0) ? 15'd1 :
                  (i_height > pngenc_pkg::DIM_MAX) ? pngenc_pkg::DIM_MAX : i_height;

    assign w_len = (r_stream < 30'(EFF_BLOCK)) ? r_stream[15:0] : EFF16;

    // block count: (d + block - 1) * recip >> 47, split in two partial products
    assign w_q = {r_p_hi, 24'd0} + {23'd0, r_p_lo};

    always_comb begin
        w_byte = 8'd0;
        case (i_cmd.src)
            pngenc_pkg::SRC_HDR: begin
                case (i_cmd.idx)
                    6'd0: w_byte = 8'd137; 6'd1: w_byte = 8'd80;
                    6'd2: w_byte = 8'd78;  6'd3: w_byte = 8'd71;
                    6'd4: w_byte = 8'd13;  6'd5: w_byte = 8'd10;
                    6'd6: w_byte = 8'd26;  6'd7: w_byte = 8'd10;
                    6'd11: w_byte = 8'd13;
                    6'd12: w_byte = 8'd73; 6'd13: w_byte = 8'd72;
                    6'd14: w_byte = 8'd68; 6'd15: w_byte = 8'd82;
                    6'd18: w_byte = {1'b0, r_fw[14:8]};
                    6'd19: w_byte = r_fw[7:0];
                    6'd22: w_byte = {1'b0, r_fh[14:8]};
                    6'd23: w_byte = r_fh[7:0];
                    6'd24: w_byte = 8'd8;  6'd25: w_byte = 8'd2;
                    6'd29: w_byte = ~r_crc[31:24]; 6'd30: w_byte = ~r_crc[23:16];
                    6'd31: w_byte = ~r_crc[15:8];  6'd32: w_byte = ~r_crc[7:0];
                    6'd33: w_byte = r_idat_len[31:24]; 6'd34: w_byte = r_idat_len[23:16];
                    6'd35: w_byte = r_idat_len[15:8];  6'd36: w_byte = r_idat_len[7:0];
                    6'd37: w_byte = 8'd73; 6'd38: w_byte = 8'd68;
                    6'd39: w_byte = 8'd65; 6'd40: w_byte = 8'd84;
                    6'd41: w_byte = 8'h78; 6'd42: w_byte = 8'h01;
                    default: w_byte = 8'd0;
                endcase
            end
            pngenc_pkg::SRC_BLKHDR: begin
                case (i_cmd.idx)
                    6'd0: w_byte = {7'd0, (r_stream <= 30'(EFF_BLOCK))};
                    6'd1: w_byte = w_len[7:0];
                    6'd2: w_byte = w_len[15:8];
                    6'd3: w_byte = ~w_len[7:0];
                    default: w_byte = ~w_len[15:8];
                endcase
            end
            pngenc_pkg::SRC_DATA: begin
                case (i_cmd.dsel)
                    2'd0: w_byte = 8'd0;
                    2'd1: w_byte = r_r;
                    2'd2: w_byte = r_g;
                    default: w_byte = r_b;
                endcase
            end
            pngenc_pkg::SRC_TRAIL: begin
                case (i_cmd.idx)
                    6'd0: w_byte = r_sb[15:8]; 6'd1: w_byte = r_sb[7:0];
                    6'd2: w_byte = r_sa[15:8]; 6'd3: w_byte = r_sa[7:0];
                    6'd4: w_byte = ~r_crc[31:24]; 6'd5: w_byte = ~r_crc[23:16];
                    6'd6: w_byte = ~r_crc[15:8];  6'd7: w_byte = ~r_crc[7:0];
                    6'd12: w_byte = 8'd73; 6'd13: w_byte = 8'd69;
                    6'd14: w_byte = 8'd78; 6'd15: w_byte = 8'd68;
                    6'd16: w_byte = ~r_crc[31:24]; 6'd17: w_byte = ~r_crc[23:16];
                    6'd18: w_byte = ~r_crc[15:8];  6'd19: w_byte = ~r_crc[7:0];
                    default: w_byte = 8'd0;
                endcase
            end
            default: w_byte = 8'd0;
        endcase
    end

    assign w_sa = {1'b0, r_sa} + {9'd0, w_byte};
    assign w_sb = {1'b0, r_sb} +
        {1'b0, (w_sa >= {1'b0, pngenc_pkg::ADLER_MOD}) ? (w_sa[15:0] - pngenc_pkg::ADLER_MOD)
                                                        : w_sa[15:0]};

    // output register doubles as one-deep buffer; run_last is patched when the
    // pixel ends without a trailer (CHECK state decides after last data byte)
    assign o_out_free = !r_oval || !i_stall;
    assign o_valid = r_oval && !r_last_pend;
    assign o_item  = r_out;

    assign o_sts.col_zero    = (r_col == 14'd0);
    assign o_sts.blk_zero    = (r_blk == 16'd0);
    assign o_sts.stream_zero = (r_stream == 30'd0);
    assign o_sts.active      = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '1; r_sa <= 16'd1; r_sb <= '0;
            r_col <= '0; r_blk <= '0; r_stream <= '0; r_active <= 1'b0;
            r_fw <= 15'd1; r_fh <= 15'd1;
            r_oval <= 1'b0; r_last_pend <= 1'b0;
        end else begin
            if (i_cmd.emit) r_oval <= 1'b1;
            else if (r_oval && !r_last_pend && !i_stall) r_oval <= 1'b0;
            if (i_cmd.start_frame) begin
                r_fw <= w_fw; r_fh <= w_fh;
                r_crc <= '1; r_sa <= 16'd1; r_sb <= '0;
                r_col <= '0; r_blk <= '0; r_active <= 1'b0;
                r_d <= 30'({15'd0, w_fh} * 30'({15'd0, w_fw} * 3 + 1));
            end
            if (i_cmd.load_pixel) begin
                r_r <= i_item.red; r_g <= i_item.green; r_b <= i_item.blue;
            end
            // IDAT length: d + 5*nb + 6, ready long before header byte 33
            r_x    <= {1'b0, r_d} + 31'(EFF_BLOCK - 1);
            r_p_lo <= 55'(r_x) * 55'(NB_RECIP[23:0]);
            r_p_hi <= 54'(r_x) * 54'(NB_RECIP[46:24]);
            r_nb   <= w_q[77:47];
            r_idat_len <= 32'(r_d) + 32'(r_nb) * 32'd5 + 32'd6;
            if (i_cmd.src == pngenc_pkg::SRC_HDR && i_cmd.emit) begin
                if (i_cmd.idx == 6'd0) r_stream <= r_d;
                if (i_cmd.idx == 6'd42) r_active <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out.out_byte <= w_byte;
                r_out.run_last <= i_cmd.last;
                r_out.file_end <= i_cmd.fend;
                r_last_pend <= (i_cmd.src == pngenc_pkg::SRC_DATA) && i_cmd.pix_done;
                if (i_cmd.crc_close) r_crc <= '1;
                else if (i_cmd.crc_en) r_crc <= pngenc_pkg::crc_upd(r_crc, w_byte);
                if (i_cmd.src == pngenc_pkg::SRC_BLKHDR && i_cmd.idx == 6'd4) r_blk <= w_len;
                if (i_cmd.src == pngenc_pkg::SRC_DATA) begin
                    r_sa <= (w_sa >= {1'b0, pngenc_pkg::ADLER_MOD}) ?
                            (w_sa[15:0] - pngenc_pkg::ADLER_MOD) : w_sa[15:0];
                    r_sb <= (w_sb >= {1'b0, pngenc_pkg::ADLER_MOD}) ?
                            (w_sb[15:0] - pngenc_pkg::ADLER_MOD) : w_sb[15:0];
                    if (r_blk != 16'd0) r_blk <= r_blk - 16'd1;
                    if (r_stream != 30'd0) r_stream <= r_stream - 30'd1;
                end
                if (i_cmd.end_frame) begin
                    r_active <= 1'b0; r_sa <= 16'd1; r_sb <= '0;
                end
            end
            if (i_cmd.pix_done) begin
                if ({1'b0, r_col} + 15'd1 >= r_fw) r_col <= '0;
                else r_col <= r_col + 14'd1;
            end
            if (r_last_pend && !i_cmd.emit) begin
                // decided in CHECK: trailer follows or this byte ends the run
                r_last_pend <= 1'b0;
                r_out.run_last <= (r_stream != 30'd0);
            end
        end
    end

endmodule

/* rtl/core/png_stored_rgb_encoder.sv */
// ----------------------------------------------------------------------------
// png_stored_rgb_encoder: 8-bit RGB PNG writer with stored deflate blocks
//
//  channel | signals                          | dir
//  input   | i_valid, o_stall, i_item         | in
//  output  | o_valid, i_stall, o_item         | out
//  config  | i_cfg_valid, o_cfg_ready, idx/dat| in
//
// One byte per cycle within a byte sequence while the output is not stalled.
// Start: the command is accepted, then 43 header bytes follow. Pixel: it is
// accepted, 3 or 4 data bytes follow, then a check state; a block header adds
// a turn state and 5 bytes, and the end of the image adds 20 trailer bytes.
// Items are handled one at a time; the byte sequencer sets the rate.
// Reset is synchronous; output stalls hold the sequencer in place.
// ----------------------------------------------------------------------------
module png_stored_rgb_encoder #(
    parameter int BLOCK_MAX_BYTES = 65535
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  pngenc_pkg::t_in_item  i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output pngenc_pkg::t_out_item o_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [14:0]           i_cfg_data
);

    logic [14:0] r_width, r_height;
    pngenc_pkg::t_cmd    w_cmd;
    pngenc_pkg::t_status w_sts;
    logic w_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 15'd1; r_height <= 15'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pngenc_pkg::CFG_WIDTH) r_width <= i_cfg_data;
            if (i_cfg_index == pngenc_pkg::CFG_HEIGHT) r_height <= i_cfg_data;
        end
    end

    pngenc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_op(i_item.operation),
        .o_stall(o_stall), .i_out_free(w_free), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    pngenc_dp #(.BLOCK_MAX_BYTES(BLOCK_MAX_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_width(r_width), .i_height(r_height),
        .i_item(i_item), .i_cmd(w_cmd), .o_sts(w_sts), .o_out_free(w_free),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

endmodule
